/* rtl/gas_pkg.sv */
// Shared types, constants and helper functions of the grid A* path search block.
// Used by every module of the block but gas_ram; depends on nothing else.
package gas_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int HEAP_DEPTH = 32768;
   localparam int CELLS      = MAX_ROWS * MAX_COLS;

   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int DIM_W   = 7;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int HEAP_AW = $clog2(HEAP_DEPTH);
   localparam int CNT_W   = $clog2(HEAP_DEPTH + 1);
   localparam int SEQ_W   = $clog2(8 * CELLS + 2);
   localparam int COST_W  = $clog2(14 * CELLS + 10 * (MAX_ROWS + MAX_COLS) + 1);
   localparam int NB_W    = DIM_W + 1;

   // Byte addresses of the registers on the APB-style port.
   localparam logic [2:0] ADDR_ROW_COUNT = 3'd0;
   localparam logic [2:0] ADDR_COL_COUNT = 3'd4;

   localparam logic [COST_W-1:0] COST_STRAIGHT = COST_W'(10);
   localparam logic [COST_W-1:0] COST_DIAG     = COST_W'(14);

   localparam logic [1:0] STEP_NEG  = 2'b11;
   localparam logic [1:0] STEP_ZERO = 2'b00;
   localparam logic [1:0] STEP_POS  = 2'b01;

   localparam logic [2:0] LAST_STEP = 3'd7;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_SEARCH = 2'd1,
      MODE_PARENT = 2'd2,
      MODE_NOP    = 2'd3
   } gas_mode_type;

   typedef struct packed {
      logic [COST_W-1:0] f;
      logic [COST_W-1:0] g;
      logic [SEQ_W-1:0]  seq;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } gas_entry_type;

   typedef struct packed {
      logic              closed;
      logic              pvalid;
      logic [ROW_W-1:0]  prow;
      logic [COL_W-1:0]  pcol;
      logic [COST_W-1:0] pf;
   } gas_meta_type;

   localparam int ENTRY_W = $bits(gas_entry_type);
   localparam int META_W  = $bits(gas_meta_type);

   typedef enum logic [4:0] {
      OP_INIT, OP_IDLE, OP_LOAD, OP_NOP, OP_PREAD, OP_PRESP,
      OP_CLEAR, OP_SEED, OP_POP0, OP_POP1, OP_POP2,
      OP_SD0, OP_SD1, OP_SD2, OP_EX0, OP_EX1,
      OP_NB0, OP_NB1, OP_NB2, OP_NB3, OP_CALC, OP_PAR,
      OP_SU0, OP_SU1, OP_NEXT, OP_OK, OP_FAIL
   } gas_op_type;

   typedef struct packed {
      gas_op_type op;
   } gas_cmd_type;

   typedef struct packed {
      gas_mode_type req_mode;
      logic clr_last;
      logic cnt_zero;
      logic sd_leaf;
      logic sd_more;
      logic is_goal;
      logic u_on_map;
      logic closed;
      logic n_on_map;
      logic n_skip;
      logic diag;
      logic corner_open;
      logic heap_full;
      logic idx_zero;
      logic su_more;
      logic k_last;
   } gas_status_type;

   function automatic logic entry_before(gas_entry_type a, gas_entry_type b);
      if (a.f != b.f) begin
         return a.f < b.f;
      end
      return a.seq < b.seq;
   endfunction

   function automatic logic [CELL_AW-1:0] cell_index(logic [ROW_W-1:0] row,
                                                      logic [COL_W-1:0] col);
      return CELL_AW'(int'(row) * MAX_COLS + int'(col));
   endfunction

   function automatic logic [1:0] step_dr(logic [2:0] k);
      case (k)
         3'd0: return STEP_NEG;
         3'd1: return STEP_POS;
         3'd4: return STEP_POS;
         3'd5: return STEP_POS;
         3'd6: return STEP_NEG;
         3'd7: return STEP_NEG;
         default: return STEP_ZERO;
      endcase
   endfunction

   function automatic logic [1:0] step_dc(logic [2:0] k);
      case (k)
         3'd2: return STEP_POS;
         3'd3: return STEP_NEG;
         3'd4: return STEP_NEG;
         3'd5: return STEP_POS;
         3'd6: return STEP_POS;
         3'd7: return STEP_NEG;
         default: return STEP_ZERO;
      endcase
   endfunction

endpackage

/* rtl/gas_ram.sv */
// Generic single-clock RAM: one write port and one read port with registered read data.
// Used for the grid, the per-cell search records and the open-list heap.
module gas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gas_datapath.sv */
// Datapath of the grid A* search: grid, per-cell records, open-list heap and result registers.
// Depends on gas_pkg and gas_ram; driven by the commands of gas_ctrl.
module gas_datapath
   import gas_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  gas_cmd_type          cmd,
   output gas_status_type       status,
   input  logic                 start,
   input  logic [DIM_W-1:0]     eff_rows,
   input  logic [DIM_W-1:0]     eff_cols,
   input  logic [1:0]           req_mode,
   input  logic [ROW_W-1:0]     req_cell_row,
   input  logic [COL_W-1:0]     req_cell_col,
   input  logic                 req_cell_open,
   input  logic [ROW_W-1:0]     req_start_row,
   input  logic [COL_W-1:0]     req_start_col,
   input  logic [ROW_W-1:0]     req_goal_row,
   input  logic [COL_W-1:0]     req_goal_col,
   output logic                 rsp_valid,
   output logic                 rsp_goal_found,
   output logic                 rsp_parent_valid,
   output logic [ROW_W-1:0]     rsp_parent_row,
   output logic [COL_W-1:0]     rsp_parent_col
);

   // Request fields
   logic [ROW_W-1:0] cell_row_ff, start_row_ff, goal_row_ff;
   logic [COL_W-1:0] cell_col_ff, start_col_ff, goal_col_ff;
   logic             cell_open_ff;

   // Search control and work registers
   logic [CELL_AW-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [HEAP_AW-1:0] idx_ff, idx_in;
   logic [2:0]         k_ff, k_in;
   gas_entry_type      top_ff, top_in;
   gas_entry_type      ent_ff, ent_in;
   gas_entry_type      lch_ff, lch_in;
   gas_meta_type       nmeta_ff, nmeta_in;
   logic [ROW_W-1:0]   nr_ff, nr_in;
   logic [COL_W-1:0]   nc_ff, nc_in;
   logic [COST_W-1:0]  g_ff, g_in, f_ff, f_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              goal_found_ff, goal_found_in;
   logic              pvalid_ff, pvalid_in;
   logic [ROW_W-1:0]  prow_ff, prow_in;
   logic [COL_W-1:0]  pcol_ff, pcol_in;

   // Memory ports
   logic               grid_we, grid_wd, grid_rd;
   logic [CELL_AW-1:0] grid_wa, grid_ra;
   logic               meta_we;
   logic [CELL_AW-1:0] meta_wa, meta_ra;
   gas_meta_type       meta_wd, meta_rd;
   logic               heap_we;
   logic [HEAP_AW-1:0] heap_wa, heap_ra;
   gas_entry_type      heap_wd, heap_rd;

   gas_ram #(.WIDTH(1), .DEPTH(CELLS)) u_grid (
      .clock(clock), .wr_en(grid_we), .wr_addr(grid_wa), .wr_data(grid_wd),
      .rd_addr(grid_ra), .rd_data(grid_rd)
   );

   gas_ram #(.WIDTH(META_W), .DEPTH(CELLS)) u_meta (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(meta_wd),
      .rd_addr(meta_ra), .rd_data(meta_rd)
   );

   gas_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_heap (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
      .rd_addr(heap_ra), .rd_data(heap_rd)
   );

   // Neighbor coordinates of the expanded cell for the current step.
   logic [1:0]        dr, dc;
   logic [NB_W-1:0]   nr_full, nc_full;
   logic              n_on_map;
   assign dr      = step_dr(k_ff);
   assign dc      = step_dc(k_ff);
   assign nr_full = NB_W'(top_ff.row) + {{(NB_W-2){dr[1]}}, dr};
   assign nc_full = NB_W'(top_ff.col) + {{(NB_W-2){dc[1]}}, dc};
   assign n_on_map = !nr_full[NB_W-1] && !nc_full[NB_W-1]
                     && (nr_full[DIM_W-1:0] < eff_rows) && (nc_full[DIM_W-1:0] < eff_cols);

   // Heap child positions for the sift-down.
   logic [CNT_W:0]  lch_pos, rch_pos;
   logic            has_r;
   gas_entry_type   best;
   logic [HEAP_AW-1:0] best_idx;
   assign lch_pos = (CNT_W+1)'(idx_ff) * (CNT_W+1)'(2) + (CNT_W+1)'(1);
   assign rch_pos = lch_pos + (CNT_W+1)'(1);
   assign has_r   = rch_pos < {1'b0, cnt_ff};
   assign best    = (has_r && entry_before(heap_rd, lch_ff)) ? heap_rd : lch_ff;
   assign best_idx = (has_r && entry_before(heap_rd, lch_ff)) ? HEAP_AW'(rch_pos)
                                                                : HEAP_AW'(lch_pos);

   logic [HEAP_AW-1:0] par_idx;
   assign par_idx = HEAP_AW'((idx_ff - HEAP_AW'(1)) >> 1);

   // Heuristic: Manhattan distance to the goal times ten.
   logic [ROW_W-1:0]  hd_row;
   logic [COL_W-1:0]  hd_col;
   logic [DIM_W-1:0]  hsum;
   logic [COST_W-1:0] h10, step_g;
   assign hd_row = (goal_row_ff > nr_ff) ? goal_row_ff - nr_ff : nr_ff - goal_row_ff;
   assign hd_col = (goal_col_ff > nc_ff) ? goal_col_ff - nc_ff : nc_ff - goal_col_ff;
   assign hsum   = DIM_W'(hd_row) + DIM_W'(hd_col);
   assign h10    = (COST_W'(hsum) << 3) + (COST_W'(hsum) << 1);
   assign step_g = top_ff.g + (k_ff[2] ? COST_DIAG : COST_STRAIGHT);

   logic par_better;
   assign par_better = !nmeta_ff.pvalid || (nmeta_ff.pf > f_ff);

   always_comb begin
      status.req_mode    = gas_mode_type'(req_mode);
      status.clr_last    = clr_ff == {CELL_AW{1'b1}};
      status.cnt_zero    = cnt_ff == '0;
      status.sd_leaf     = lch_pos >= {1'b0, cnt_ff};
      status.sd_more     = entry_before(best, ent_ff);
      status.is_goal     = (top_ff.row == goal_row_ff) && (top_ff.col == goal_col_ff);
      status.u_on_map    = (DIM_W'(top_ff.row) < eff_rows) && (DIM_W'(top_ff.col) < eff_cols);
      status.closed      = meta_rd.closed;
      status.n_on_map    = n_on_map;
      status.n_skip      = meta_rd.closed || !grid_rd;
      status.diag        = k_ff[2];
      status.corner_open = grid_rd;
      status.heap_full   = cnt_ff >= CNT_W'(HEAP_DEPTH);
      status.idx_zero    = idx_ff == '0;
      status.su_more     = entry_before(ent_ff, heap_rd);
      status.k_last      = k_ff == LAST_STEP;
   end

   always_comb begin
      clr_in = clr_ff;  cnt_in = cnt_ff;  seq_in = seq_ff;  idx_in = idx_ff;
      k_in = k_ff;  top_in = top_ff;  ent_in = ent_ff;  lch_in = lch_ff;
      nmeta_in = nmeta_ff;  nr_in = nr_ff;  nc_in = nc_ff;  g_in = g_ff;  f_in = f_ff;
      rsp_valid_in = 1'b0;  goal_found_in = 1'b0;  pvalid_in = 1'b0;
      prow_in = '0;  pcol_in = '0;
      grid_we = 1'b0;  grid_wa = cell_index(cell_row_ff, cell_col_ff);  grid_wd = cell_open_ff;
      grid_ra = cell_index(nr_full[ROW_W-1:0], nc_full[COL_W-1:0]);
      meta_we = 1'b0;  meta_wa = clr_ff;  meta_wd = '0;
      meta_ra = cell_index(cell_row_ff, cell_col_ff);
      heap_we = 1'b0;  heap_wa = idx_ff;  heap_wd = ent_ff;  heap_ra = '0;

      case (cmd.op)
         OP_IDLE: begin
            clr_in = '0;
         end
         OP_INIT, OP_CLEAR: begin
            meta_we = 1'b1;
            clr_in  = clr_ff + CELL_AW'(1);
         end
         OP_LOAD: begin
            grid_we      = 1'b1;
            rsp_valid_in = 1'b1;
         end
         OP_NOP: begin
            rsp_valid_in = 1'b1;
         end
         OP_PREAD: begin
            meta_ra = cell_index(cell_row_ff, cell_col_ff);
         end
         OP_PRESP: begin
            rsp_valid_in = 1'b1;
            pvalid_in    = meta_rd.pvalid;
            prow_in      = meta_rd.pvalid ? meta_rd.prow : '0;
            pcol_in      = meta_rd.pvalid ? meta_rd.pcol : '0;
         end
         OP_SEED: begin
            heap_we = 1'b1;
            heap_wa = '0;
            heap_wd = '{f: '0, g: '0, seq: '0, row: start_row_ff, col: start_col_ff};
            cnt_in  = CNT_W'(1);
            seq_in  = SEQ_W'(1);
         end
         OP_POP0: begin
            heap_ra = '0;
         end
         OP_POP1: begin
            top_in  = heap_rd;
            heap_ra = HEAP_AW'(cnt_ff - CNT_W'(1));
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         OP_POP2: begin
            ent_in = heap_rd;
            idx_in = '0;
         end
         OP_SD0: begin
            heap_ra = HEAP_AW'(lch_pos);
            if (status.sd_leaf && cnt_ff != '0) begin
               heap_we = 1'b1;
            end
         end
         OP_SD1: begin
            lch_in  = heap_rd;
            heap_ra = HEAP_AW'(rch_pos);
         end
         OP_SD2: begin
            heap_we = 1'b1;
            if (status.sd_more) begin
               heap_wd = best;
               idx_in  = best_idx;
            end
         end
         OP_EX0: begin
            meta_ra = cell_index(top_ff.row, top_ff.col);
         end
         OP_EX1: begin
            meta_we        = !meta_rd.closed;
            meta_wa        = cell_index(top_ff.row, top_ff.col);
            meta_wd        = meta_rd;
            meta_wd.closed = 1'b1;
            k_in           = '0;
         end
         OP_NB0: begin
            nr_in   = nr_full[ROW_W-1:0];
            nc_in   = nc_full[COL_W-1:0];
            meta_ra = cell_index(nr_full[ROW_W-1:0], nc_full[COL_W-1:0]);
         end
         OP_NB1: begin
            nmeta_in = meta_rd;
            grid_ra  = cell_index(top_ff.row, nc_ff);
         end
         OP_NB2: begin
            grid_ra = cell_index(nr_ff, top_ff.col);
         end
         OP_CALC: begin
            g_in = step_g;
            f_in = step_g + h10;
         end
         OP_PAR: begin
            if (par_better) begin
               meta_we = 1'b1;
               meta_wa = cell_index(nr_ff, nc_ff);
               meta_wd = '{closed: 1'b0, pvalid: 1'b1, prow: top_ff.row,
                           pcol: top_ff.col, pf: f_ff};
            end
            if (!status.heap_full) begin
               ent_in = '{f: f_ff, g: g_ff, seq: seq_ff, row: nr_ff, col: nc_ff};
               seq_in = seq_ff + SEQ_W'(1);
               idx_in = HEAP_AW'(cnt_ff);
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         OP_SU0: begin
            heap_ra = par_idx;
            if (status.idx_zero) begin
               heap_we = 1'b1;
            end
         end
         OP_SU1: begin
            heap_we = 1'b1;
            if (status.su_more) begin
               heap_wd = heap_rd;
               idx_in  = par_idx;
            end
         end
         OP_NEXT: begin
            k_in = k_ff + 3'd1;
         end
         OP_OK: begin
            rsp_valid_in  = 1'b1;
            goal_found_in = 1'b1;
         end
         OP_FAIL: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         cnt_ff       <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_IDLE && start) begin
         cell_row_ff  <= req_cell_row;
         cell_col_ff  <= req_cell_col;
         cell_open_ff <= req_cell_open;
         start_row_ff <= req_start_row;
         start_col_ff <= req_start_col;
         goal_row_ff  <= req_goal_row;
         goal_col_ff  <= req_goal_col;
      end
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      top_ff        <= top_in;
      ent_ff        <= ent_in;
      lch_ff        <= lch_in;
      nmeta_ff      <= nmeta_in;
      nr_ff         <= nr_in;
      nc_ff         <= nc_in;
      g_ff          <= g_in;
      f_ff          <= f_in;
      goal_found_ff <= goal_found_in;
      pvalid_ff     <= pvalid_in;
      prow_ff       <= prow_in;
      pcol_ff       <= pcol_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_goal_found   = goal_found_ff;
   assign rsp_parent_valid = pvalid_ff;
   assign rsp_parent_row   = prow_ff;
   assign rsp_parent_col   = pcol_ff;

   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(HEAP_DEPTH))
      else $error("open list count beyond heap depth");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_found_only_search: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_goal_found |-> !rsp_parent_valid)
      else $error("search result carries parent data");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_PAR && !status.heap_full |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("push did not grow the open list");

endmodule

/* rtl/gas_ctrl.sv */
// Controller state machine of the grid A* search; sequences the datapath by commands.
// Depends on gas_pkg.
module gas_ctrl
   import gas_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  gas_status_type status,
   output gas_cmd_type    cmd,
   output logic           busy
);

   gas_op_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OP_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = state_ff;
      busy     = state_ff != OP_IDLE;
      case (state_ff)
         OP_INIT:  state_in = status.clr_last ? OP_IDLE : OP_INIT;
         OP_IDLE: begin
            if (start) begin
               case (status.req_mode)
                  MODE_LOAD:   state_in = OP_LOAD;
                  MODE_SEARCH: state_in = OP_CLEAR;
                  MODE_PARENT: state_in = OP_PREAD;
                  default:     state_in = OP_NOP;
               endcase
            end
         end
         OP_LOAD:  state_in = OP_IDLE;
         OP_NOP:   state_in = OP_IDLE;
         OP_PREAD: state_in = OP_PRESP;
         OP_PRESP: state_in = OP_IDLE;
         OP_CLEAR: state_in = status.clr_last ? OP_SEED : OP_CLEAR;
         OP_SEED:  state_in = OP_POP0;
         OP_POP0:  state_in = status.cnt_zero ? OP_FAIL : OP_POP1;
         OP_POP1:  state_in = OP_POP2;
         OP_POP2:  state_in = OP_SD0;
         OP_SD0:   state_in = status.sd_leaf ? OP_EX0 : OP_SD1;
         OP_SD1:   state_in = OP_SD2;
         OP_SD2:   state_in = status.sd_more ? OP_SD0 : OP_EX0;
         OP_EX0: begin
            if (status.is_goal) begin
               state_in = OP_OK;
            end else if (!status.u_on_map) begin
               state_in = OP_POP0;
            end else begin
               state_in = OP_EX1;
            end
         end
         OP_EX1:   state_in = status.closed ? OP_POP0 : OP_NB0;
         OP_NB0:   state_in = status.n_on_map ? OP_NB1 : OP_NEXT;
         OP_NB1: begin
            if (status.n_skip) begin
               state_in = OP_NEXT;
            end else begin
               state_in = status.diag ? OP_NB2 : OP_CALC;
            end
         end
         OP_NB2:   state_in = status.corner_open ? OP_NB3 : OP_NEXT;
         OP_NB3:   state_in = status.corner_open ? OP_CALC : OP_NEXT;
         OP_CALC:  state_in = OP_PAR;
         OP_PAR:   state_in = status.heap_full ? OP_NEXT : OP_SU0;
         OP_SU0:   state_in = status.idx_zero ? OP_NEXT : OP_SU1;
         OP_SU1:   state_in = status.su_more ? OP_SU0 : OP_NEXT;
         OP_NEXT:  state_in = status.k_last ? OP_POP0 : OP_NB0;
         OP_OK:    state_in = OP_IDLE;
         OP_FAIL:  state_in = OP_IDLE;
         default:  state_in = OP_INIT;
      endcase
   end

endmodule

/* rtl/grid_astar_path_search.sv */
// Grid A* path search (8-connected) with an APB-style register port for the grid size.
// Each request ends in a result strobe; the result strobe rsp_valid is high for one cycle
// and cannot be stalled, so the receiver must take it then. A search first clears the
// per-cell record memory, then pops the heap and sifts it down, and for each of the 8
// neighbors checks the cell and, when it is pushed, sifts it up the heap, until the goal
// is popped or the heap is empty. After reset the block is busy while that memory is cleared.
// Depends on gas_pkg, gas_ctrl, gas_datapath and gas_ram.
module grid_astar_path_search
   import gas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [ROW_W-1:0]  req_cell_row,
   input  logic [COL_W-1:0]  req_cell_col,
   input  logic              req_cell_open,
   input  logic [ROW_W-1:0]  req_start_row,
   input  logic [COL_W-1:0]  req_start_col,
   input  logic [ROW_W-1:0]  req_goal_row,
   input  logic [COL_W-1:0]  req_goal_col,
   output logic              rsp_valid,
   output logic              rsp_goal_found,
   output logic              rsp_parent_valid,
   output logic [ROW_W-1:0]  rsp_parent_row,
   output logic [COL_W-1:0]  rsp_parent_col,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [DIM_W-1:0] row_count_ff, col_count_ff;
   logic [DIM_W-1:0] eff_rows, eff_cols;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DIM_W'(64);
         col_count_ff <= DIM_W'(64);
      end else if (csr_wr) begin
         if (paddr[2]) begin
            col_count_ff <= pwdata[DIM_W-1:0];
         end else begin
            row_count_ff <= pwdata[DIM_W-1:0];
         end
      end
   end

   assign prdata   = paddr[2] ? {{(32-DIM_W){1'b0}}, col_count_ff}
                              : {{(32-DIM_W){1'b0}}, row_count_ff};
   assign eff_rows = (row_count_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : row_count_ff;
   assign eff_cols = (col_count_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : col_count_ff;

   gas_cmd_type    cmd;
   gas_status_type status;

   gas_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .status(status),
      .cmd(cmd), .busy(busy)
   );

   gas_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .start(start),
      .eff_rows(eff_rows), .eff_cols(eff_cols),
      .req_mode(req_mode), .req_cell_row(req_cell_row), .req_cell_col(req_cell_col),
      .req_cell_open(req_cell_open), .req_start_row(req_start_row),
      .req_start_col(req_start_col), .req_goal_row(req_goal_row),
      .req_goal_col(req_goal_col),
      .rsp_valid(rsp_valid), .rsp_goal_found(rsp_goal_found),
      .rsp_parent_valid(rsp_parent_valid), .rsp_parent_row(rsp_parent_row),
      .rsp_parent_col(rsp_parent_col)
   );

endmodule

/* dv/grid_astar_path_search_checker.sv */
// Checker for the grid A* path search block: watches the request, response and register ports.
// It predicts each response with its own search and compares field by field.
// Depends on gas_pkg.
module grid_astar_path_search_checker
   import gas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [ROW_W-1:0]  req_cell_row,
   input  logic [COL_W-1:0]  req_cell_col,
   input  logic              req_cell_open,
   input  logic [ROW_W-1:0]  req_start_row,
   input  logic [COL_W-1:0]  req_start_col,
   input  logic [ROW_W-1:0]  req_goal_row,
   input  logic [COL_W-1:0]  req_goal_col,
   input  logic              rsp_valid,
   input  logic              rsp_goal_found,
   input  logic              rsp_parent_valid,
   input  logic [ROW_W-1:0]  rsp_parent_row,
   input  logic [COL_W-1:0]  rsp_parent_col,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output int                fail_count,
   output int                outstanding
);

   typedef struct {
      logic             goal_found;
      logic             parent_valid;
      logic [ROW_W-1:0] parent_row;
      logic [COL_W-1:0] parent_col;
   } route_answer_type;

   route_answer_type answer_queue[$];

   logic [DIM_W-1:0] rows_in_use;
   logic [DIM_W-1:0] cols_in_use;
   logic             map_open  [CELLS];
   logic             visited   [CELLS];
   logic             link_valid[CELLS];
   int               link_row  [CELLS];
   int               link_col  [CELLS];
   int               link_f    [CELLS];

   int heap_f  [HEAP_DEPTH];
   int heap_g  [HEAP_DEPTH];
   int heap_seq[HEAP_DEPTH];
   int heap_row[HEAP_DEPTH];
   int heap_col[HEAP_DEPTH];
   int heap_count;
   int push_count;

   const int move_dr[8]   = '{-1, 1, 0, 0, 1, 1, -1, -1};
   const int move_dc[8]   = '{0, 0, 1, -1, -1, 1, 1, -1};
   const int move_cost[8] = '{10, 10, 10, 10, 14, 14, 14, 14};

   assign outstanding = answer_queue.size();

   function automatic bit within_map(int r, int c);
      int nr;
      int nc;
      nr = (rows_in_use < MAX_ROWS) ? int'(rows_in_use) : MAX_ROWS;
      nc = (cols_in_use < MAX_COLS) ? int'(cols_in_use) : MAX_COLS;
      return r >= 0 && c >= 0 && r < nr && c < nc;
   endfunction

   function automatic bit earlier(int fa, int sa, int fb, int sb);
      if (fa != fb) begin
         return fa < fb;
      end
      return sa < sb;
   endfunction

   task automatic heap_insert(int f, int g, int r, int c);
      int i;
      int p;
      int s;
      if (heap_count >= HEAP_DEPTH) begin
         return;
      end
      s = push_count++;
      i = heap_count++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!earlier(f, s, heap_f[p], heap_seq[p])) break;
         heap_f[i] = heap_f[p]; heap_g[i] = heap_g[p]; heap_seq[i] = heap_seq[p];
         heap_row[i] = heap_row[p]; heap_col[i] = heap_col[p];
         i = p;
      end
      heap_f[i] = f; heap_g[i] = g; heap_seq[i] = s; heap_row[i] = r; heap_col[i] = c;
   endtask

   // The top entry comes back through the output arguments.
   task automatic heap_take(output int g, output int r, output int c);
      int lf, lg, ls, lr, lc;
      int i, l, m;
      g = heap_g[0]; r = heap_row[0]; c = heap_col[0];
      heap_count--;
      lf = heap_f[heap_count]; lg = heap_g[heap_count]; ls = heap_seq[heap_count];
      lr = heap_row[heap_count]; lc = heap_col[heap_count];
      i = 0;
      forever begin
         l = 2 * i + 1;
         if (l >= heap_count) break;
         m = l;
         if (l + 1 < heap_count &&
             earlier(heap_f[l+1], heap_seq[l+1], heap_f[l], heap_seq[l])) begin
            m = l + 1;
         end
         if (!earlier(heap_f[m], heap_seq[m], lf, ls)) break;
         heap_f[i] = heap_f[m]; heap_g[i] = heap_g[m]; heap_seq[i] = heap_seq[m];
         heap_row[i] = heap_row[m]; heap_col[i] = heap_col[m];
         i = m;
      end
      if (heap_count > 0) begin
         heap_f[i] = lf; heap_g[i] = lg; heap_seq[i] = ls; heap_row[i] = lr; heap_col[i] = lc;
      end
   endtask

   task automatic find_route(input int sr, input int sc, input int gr, input int gc,
                             output logic found);
      int ug, ur, uc, r, c, k, idx, g, f, dr, dc;
      for (int i = 0; i < CELLS; i++) begin
         visited[i] = 1'b0; link_valid[i] = 1'b0;
         link_row[i] = 0; link_col[i] = 0; link_f[i] = 0;
      end
      heap_count = 0;
      push_count = 0;
      found = 1'b0;
      heap_insert(0, 0, sr, sc);
      while (heap_count > 0) begin
         heap_take(ug, ur, uc);
         if (ur == gr && uc == gc) begin
            found = 1'b1;
            return;
         end
         if (!within_map(ur, uc) || visited[ur * MAX_COLS + uc]) continue;
         visited[ur * MAX_COLS + uc] = 1'b1;
         for (k = 0; k < 8; k++) begin
            r = ur + move_dr[k];
            c = uc + move_dc[k];
            if (!within_map(r, c)) continue;
            idx = r * MAX_COLS + c;
            if (visited[idx] || !map_open[idx]) continue;
            // A diagonal step may not cut a blocked corner.
            if (k >= 4 && (!map_open[ur * MAX_COLS + c] || !map_open[r * MAX_COLS + uc])) continue;
            g = ug + move_cost[k];
            dr = (gr > r) ? gr - r : r - gr;
            dc = (gc > c) ? gc - c : c - gc;
            f = g + (dr + dc) * 10;
            heap_insert(f, g, r, c);
            if (!link_valid[idx] || link_f[idx] > f) begin
               link_valid[idx] = 1'b1;
               link_row[idx] = ur;
               link_col[idx] = uc;
               link_f[idx] = f;
            end
         end
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      rows_in_use = DIM_W'(64);
      cols_in_use = DIM_W'(64);
      for (int i = 0; i < CELLS; i++) begin
         map_open[i] = 1'b0; link_valid[i] = 1'b0;
      end
   end

   always @(posedge clock) begin
      route_answer_type want;
      int idx;
      if (reset) begin
         rows_in_use <= DIM_W'(64);
         cols_in_use <= DIM_W'(64);
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_ROW_COUNT) rows_in_use <= pwdata[DIM_W-1:0];
            if (paddr == ADDR_COL_COUNT) cols_in_use <= pwdata[DIM_W-1:0];
         end
         if (rsp_valid) begin
            if (answer_queue.size() == 0) begin
               report_mismatch("response with no request waiting", 1, 0);
            end else begin
               want = answer_queue.pop_front();
               if (rsp_goal_found !== want.goal_found)
                  report_mismatch("goal_found", int'(rsp_goal_found), int'(want.goal_found));
               if (rsp_parent_valid !== want.parent_valid)
                  report_mismatch("parent_valid", int'(rsp_parent_valid),
                                  int'(want.parent_valid));
               if (rsp_parent_row !== want.parent_row)
                  report_mismatch("parent_row", int'(rsp_parent_row), int'(want.parent_row));
               if (rsp_parent_col !== want.parent_col)
                  report_mismatch("parent_col", int'(rsp_parent_col), int'(want.parent_col));
            end
         end
         if (start && !busy) begin
            want = '{1'b0, 1'b0, '0, '0};
            idx = int'(req_cell_row) * MAX_COLS + int'(req_cell_col);
            case (gas_mode_type'(req_mode))
               MODE_LOAD: map_open[idx] = req_cell_open;
               MODE_SEARCH: find_route(int'(req_start_row), int'(req_start_col),
                                       int'(req_goal_row), int'(req_goal_col),
                                       want.goal_found);
               MODE_PARENT: begin
                  if (link_valid[idx]) begin
                     want.parent_valid = 1'b1;
                     want.parent_row = ROW_W'(link_row[idx]);
                     want.parent_col = COL_W'(link_col[idx]);
                  end
               end
               default: ;
            endcase
            answer_queue = {answer_queue, want};
         end
      end
   end

endmodule

/* dv/tb_grid_astar_path_search.sv */
// Testbench top for the grid A* path search block: clock, reset, requests and register writes.
// Depends on gas_pkg, grid_astar_path_search and grid_astar_path_search_checker.
module tb_grid_astar_path_search
   import gas_pkg::*;
();

   localparam int QUIET_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_mode = MODE_NOP;
   logic [ROW_W-1:0] req_cell_row = '0, req_start_row = '0, req_goal_row = '0;
   logic [COL_W-1:0] req_cell_col = '0, req_start_col = '0, req_goal_col = '0;
   logic req_cell_open = 1'b0;
   logic rsp_valid, rsp_goal_found, rsp_parent_valid;
   logic [ROW_W-1:0] rsp_parent_row;
   logic [COL_W-1:0] rsp_parent_col;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   int fail_count, outstanding;
   int quiet_cycles = 0;
   int search_count = 0, parent_count = 0, load_count = 0;
   int map_rows = 64, map_cols = 64;
   bit no_idle = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   grid_astar_path_search dut (.*);

   grid_astar_path_search_checker checker_inst (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("timeout: no activity for %0d cycles", QUIET_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(gas_mode_type mode, int cr, int cc, bit open_bit,
                               int sr, int sc, int gr, int gc, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode <= mode;
      req_cell_row <= ROW_W'(cr); req_cell_col <= COL_W'(cc);
      req_cell_open <= open_bit;
      req_start_row <= ROW_W'(sr); req_start_col <= COL_W'(sc);
      req_goal_row <= ROW_W'(gr); req_goal_col <= COL_W'(gc);
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      case (mode)
         MODE_SEARCH: search_count++;
         MODE_PARENT: parent_count++;
         MODE_LOAD:   load_count++;
         default: ;
      endcase
   endtask

   task automatic load_cell(int r, int c, bit open_bit);
      send_request(MODE_LOAD, r, c, open_bit, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 63), pick_gap());
   endtask

   task automatic search(int sr, int sc, int gr, int gc);
      send_request(MODE_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 1) == 1, sr, sc, gr, gc, pick_gap());
   endtask

   task automatic read_parent(int r, int c);
      send_request(MODE_PARENT, r, c, $urandom_range(0, 1) == 1, $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                   pick_gap());
   endtask

   // Registers change only once every response is back and the block is idle.
   task automatic set_map_size(int rows, int cols);
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
      for (int i = 0; i < 2; i++) begin
         psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
         paddr <= (i == 0) ? ADDR_ROW_COUNT : ADDR_COL_COUNT;
         pwdata <= (i == 0) ? 32'(rows) : 32'(cols);
         @(negedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         @(negedge clock);
      end
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      map_rows = (rows > 64) ? 64 : rows;
      map_cols = (cols > 64) ? 64 : cols;
   endtask

   function automatic int span(int n);
      return (n > 0) ? n - 1 : 0;
   endfunction

   task automatic random_phase(int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 28) begin
            load_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 3) != 0);
         end else if (roll < 63) begin
            if ($urandom_range(0, 6) == 0)
               search($urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom_range(0, 63));
            else
               search($urandom_range(0, span(map_rows)), $urandom_range(0, span(map_cols)),
                      $urandom_range(0, span(map_rows)), $urandom_range(0, span(map_cols)));
         end else if (roll < 95) begin
            if ($urandom_range(0, 5) == 0)
               read_parent($urandom_range(0, 63), $urandom_range(0, 63));
            else
               read_parent($urandom_range(0, span(map_rows)), $urandom_range(0, span(map_cols)));
         end else begin
            send_request(MODE_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1) == 1, $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                         pick_gap());
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Nothing is loaded yet, so the full grid only sees a search that starts on its goal.
      search(10, 10, 10, 10);
      read_parent(10, 10);

      // Every cell of the small map is written before any search can read it.
      set_map_size(6, 6);
      no_idle = 1'b1;
      for (int r = 0; r < 6; r++)
         for (int c = 0; c < 6; c++)
            load_cell(r, c, $urandom_range(0, 4) != 0);
      no_idle = 1'b0;
      load_cell(0, 0, 1'b1);
      load_cell(5, 5, 1'b1);
      search(0, 0, 5, 5);
      read_parent(5, 5);
      read_parent(0, 0);
      read_parent(63, 63);
      load_cell(2, 2, 1'b0);
      search(2, 2, 4, 4);
      read_parent(4, 4);
      search(10, 2, 3, 3);
      search(1, 1, 20, 20);
      read_parent(3, 3);
      send_request(MODE_NOP, 63, 63, 1'b1, 63, 63, 63, 63, 0);
      load_cell(2, 2, 1'b1);

      set_map_size(0, 0);
      search(0, 0, 0, 1);
      search(5, 5, 5, 5);
      set_map_size(1, 1);
      search(0, 0, 0, 0);
      search(0, 0, 1, 1);

      // The oversized row count is clipped, so the bottom row has nothing below it.
      load_cell(63, 0, 1'b1);
      load_cell(62, 0, 1'b1);
      load_cell(61, 0, 1'b0);
      set_map_size(127, 1);
      search(63, 0, 0, 0);
      read_parent(62, 0);

      set_map_size(6, 6);
      random_phase(40);

      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("covered %0d searches, %0d parent reads and %0d cell loads", search_count,
               parent_count, load_count);
      $display("map sizes from none to the full grid, including an oversized row count");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/gas_pkg.sv
rtl/gas_ram.sv
rtl/gas_datapath.sv
rtl/gas_ctrl.sv
rtl/grid_astar_path_search.sv
dv/grid_astar_path_search_checker.sv
dv/tb_grid_astar_path_search.sv
